@@ sv/art_pkg.sv @@
package art_pkg;

    // Table geometry
    localparam int SLOTS       = 8;
    localparam int MAX_RESULTS = 8;
    localparam int IDX_W       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W       = $clog2(SLOTS + 1);
    localparam int RES_W       = $clog2(MAX_RESULTS + 1);
    localparam int WAIT_W      = 26;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 24;

    // Operation codes
    localparam logic [1:0] OP_REGISTER = 2'd0;
    localparam logic [1:0] OP_ACK      = 2'd1;
    localparam logic [1:0] OP_TICK     = 2'd2;

    // Result codes
    localparam logic [2:0] EV_TRACKED     = 3'd0;
    localparam logic [2:0] EV_NOT_TRACKED = 3'd1;
    localparam logic [2:0] EV_ACKED       = 3'd2;
    localparam logic [2:0] EV_UNMATCHED   = 3'd3;
    localparam logic [2:0] EV_RETRANSMIT  = 3'd4;
    localparam logic [2:0] EV_FAILED      = 3'd5;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MAX_PENDING    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ATTEMPTS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FLOOD_TIMEOUT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DIRECT_BASE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DIRECT_PER_HOP = 3'd4;

    typedef struct packed {
        logic [3:0]  max_pending;
        logic [3:0]  max_attempts;
        logic [23:0] flood_timeout;
        logic [23:0] direct_base;
        logic [15:0] direct_per_hop;
    } cfg_t;

    typedef struct packed {
        logic [31:0] id;
        logic [31:0] ack;
        logic [31:0] deadline;
        logic [3:0]  attempts;
        logic        flood;
    } entry_t;

    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        entry_t           wr_data;
    } mem_req_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_REG,
        S_REG_WR,
        S_RD,
        S_EVAL,
        S_DROP_CHK,
        S_DROP_WR,
        S_DONE
    } state_t;

    // Add a wait to the current time, clamp at the top of the range
    function automatic logic [31:0] sat_add(input logic [31:0] now,
                                            input logic [WAIT_W-1:0] wait_ms);
        logic [32:0] sum;
        sum = {1'b0, now} + 33'(wait_ms);
        return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    endfunction

endpackage

@@ sv/art_mem.sv @@
module art_mem
(
    input  logic              clk,
    input  art_pkg::mem_req_t req,
    output art_pkg::entry_t   rd_data
);

    art_pkg::entry_t mem [art_pkg::SLOTS];

    // Write port
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rd_data <= mem[req.rd_addr];
        end
    end

endmodule

@@ sv/art_ctrl.sv @@
module art_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  art_pkg::cfg_t     cfg,
    input  logic              start,
    input  logic [1:0]        operation,
    input  logic [31:0]       now_ms,
    input  logic [31:0]       send_id,
    input  logic              want_ack,
    input  logic [31:0]       expected_ack,
    input  logic              via_flood,
    input  logic [6:0]        hop_count,
    input  logic [31:0]       ack_value,
    output logic              busy,
    output logic              valid,
    output logic [2:0]        event_res,
    output logic [31:0]       event_id,
    output logic              last,
    output art_pkg::mem_req_t mem_req,
    input  art_pkg::entry_t   rd_data
);

    localparam int CNT_W  = art_pkg::CNT_W;
    localparam int IDX_W  = art_pkg::IDX_W;
    localparam int RES_W  = art_pkg::RES_W;
    localparam int WAIT_W = art_pkg::WAIT_W;

    art_pkg::state_t state_reg, state_next;

    // Control state
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [IDX_W-1:0] sh_reg, sh_next;
    logic [RES_W-1:0] n_reg, n_next;
    logic             pend_valid_reg, pend_valid_next;
    logic             out_valid_reg, out_valid_next;
    logic             out_last_reg, out_last_next;

    // Payload state
    logic [1:0]        op_reg;
    logic [31:0]       now_reg;
    logic [31:0]       id_reg;
    logic              want_reg;
    logic [31:0]       expack_reg;
    logic              flood_reg;
    logic [6:0]        hop_reg;
    logic [31:0]       ackval_reg;
    logic [WAIT_W-1:0] wait_reg, wait_next;
    logic [2:0]        pend_res_reg, pend_res_next;
    logic [31:0]       pend_id_reg, pend_id_next;
    logic [2:0]        out_res_reg, out_res_next;
    logic [31:0]       out_id_reg, out_id_next;

    // Decisions
    logic             accept;
    logic             walk_more;
    logic             hit;
    logic             expired;
    logic             fail;
    logic             sh_more;
    logic             can_track;
    logic [CNT_W-1:0] sh_inc;
    logic [22:0]      hop_term;
    logic [23:0]      retx_wait;
    logic             push_en;
    logic [2:0]       push_res;
    logic [31:0]      push_id;
    logic             flush_en;

    assign accept    = start && (state_reg == art_pkg::S_IDLE);
    assign walk_more = (idx_reg < cnt_reg)
                     && ((op_reg == art_pkg::OP_ACK) || (n_reg < RES_W'(art_pkg::MAX_RESULTS)));
    assign hit       = (rd_data.ack == ackval_reg);
    assign expired   = !(rd_data.deadline > now_reg);
    assign fail      = (rd_data.attempts >= cfg.max_attempts);
    assign sh_inc    = CNT_W'(sh_reg) + CNT_W'(1);
    assign sh_more   = (sh_inc < cnt_reg);
    assign can_track = want_reg && (32'(cnt_reg) < 32'(cfg.max_pending))
                     && (32'(cnt_reg) < 32'(art_pkg::SLOTS));
    assign hop_term  = cfg.direct_per_hop * hop_reg;
    assign retx_wait = rd_data.flood ? cfg.flood_timeout : cfg.direct_base;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            art_pkg::S_IDLE:
            begin
                if (start)
                begin
                    unique case (operation)
                        art_pkg::OP_REGISTER: state_next = art_pkg::S_REG;
                        art_pkg::OP_ACK,
                        art_pkg::OP_TICK:     state_next = art_pkg::S_RD;
                        default:              state_next = art_pkg::S_IDLE;
                    endcase
                end
            end
            art_pkg::S_REG:
            begin
                state_next = can_track ? art_pkg::S_REG_WR : art_pkg::S_DONE;
            end
            art_pkg::S_REG_WR:
            begin
                state_next = art_pkg::S_DONE;
            end
            art_pkg::S_RD:
            begin
                state_next = walk_more ? art_pkg::S_EVAL : art_pkg::S_DONE;
            end
            art_pkg::S_EVAL:
            begin
                if (op_reg == art_pkg::OP_ACK)
                begin
                    state_next = hit ? art_pkg::S_DROP_CHK : art_pkg::S_RD;
                end
                else
                begin
                    state_next = (expired && fail) ? art_pkg::S_DROP_CHK : art_pkg::S_RD;
                end
            end
            art_pkg::S_DROP_CHK:
            begin
                if (sh_more)
                begin
                    state_next = art_pkg::S_DROP_WR;
                end
                else
                begin
                    state_next = (op_reg == art_pkg::OP_ACK) ? art_pkg::S_DONE : art_pkg::S_RD;
                end
            end
            art_pkg::S_DROP_WR:
            begin
                state_next = art_pkg::S_DROP_CHK;
            end
            art_pkg::S_DONE:
            begin
                state_next = art_pkg::S_IDLE;
            end
            default:
            begin
                state_next = art_pkg::S_IDLE;
            end
        endcase
    end

    // Datapath and memory requests per state
    always_comb
    begin
        cnt_next          = cnt_reg;
        idx_next          = idx_reg;
        sh_next           = sh_reg;
        n_next            = n_reg;
        wait_next         = wait_reg;
        push_en           = 1'b0;
        push_res          = art_pkg::EV_TRACKED;
        push_id           = rd_data.id;
        flush_en          = 1'b0;
        mem_req.rd_en     = 1'b0;
        mem_req.rd_addr   = idx_reg[IDX_W-1:0];
        mem_req.wr_en     = 1'b0;
        mem_req.wr_addr   = idx_reg[IDX_W-1:0];
        mem_req.wr_data   = rd_data;
        unique case (state_reg)
            art_pkg::S_IDLE:
            begin
                idx_next = '0;
                n_next   = '0;
            end
            art_pkg::S_REG:
            begin
                // Timeout for a first send, per-hop term included on direct sends
                wait_next = flood_reg ? WAIT_W'(cfg.flood_timeout)
                                      : WAIT_W'(cfg.direct_base) + WAIT_W'(hop_term);
                if (!can_track)
                begin
                    push_en  = 1'b1;
                    push_res = art_pkg::EV_NOT_TRACKED;
                    push_id  = id_reg;
                end
            end
            art_pkg::S_REG_WR:
            begin
                // Append the new entry after the youngest one
                mem_req.wr_en            = 1'b1;
                mem_req.wr_addr          = cnt_reg[IDX_W-1:0];
                mem_req.wr_data.id       = id_reg;
                mem_req.wr_data.ack      = expack_reg;
                mem_req.wr_data.deadline = art_pkg::sat_add(now_reg, wait_reg);
                mem_req.wr_data.attempts = 4'd1;
                mem_req.wr_data.flood    = flood_reg;
                cnt_next                 = cnt_reg + CNT_W'(1);
                push_en                  = 1'b1;
                push_res                 = art_pkg::EV_TRACKED;
                push_id                  = id_reg;
            end
            art_pkg::S_RD:
            begin
                if (walk_more)
                begin
                    mem_req.rd_en = 1'b1;
                end
                else if (op_reg == art_pkg::OP_ACK)
                begin
                    push_en  = 1'b1;
                    push_res = art_pkg::EV_UNMATCHED;
                    push_id  = '0;
                end
            end
            art_pkg::S_EVAL:
            begin
                sh_next = idx_reg[IDX_W-1:0];
                if (op_reg == art_pkg::OP_ACK)
                begin
                    if (hit)
                    begin
                        push_en  = 1'b1;
                        push_res = art_pkg::EV_ACKED;
                    end
                    else
                    begin
                        idx_next = idx_reg + CNT_W'(1);
                    end
                end
                else if (!expired)
                begin
                    idx_next = idx_reg + CNT_W'(1);
                end
                else if (fail)
                begin
                    push_en  = 1'b1;
                    push_res = art_pkg::EV_FAILED;
                    n_next   = n_reg + RES_W'(1);
                end
                else
                begin
                    // Retransmit: bump attempts, rearm with the base timeout
                    mem_req.wr_en            = 1'b1;
                    mem_req.wr_data.attempts = rd_data.attempts + 4'd1;
                    mem_req.wr_data.deadline = art_pkg::sat_add(now_reg, WAIT_W'(retx_wait));
                    push_en                  = 1'b1;
                    push_res                 = art_pkg::EV_RETRANSMIT;
                    n_next                   = n_reg + RES_W'(1);
                    idx_next                 = idx_reg + CNT_W'(1);
                end
            end
            art_pkg::S_DROP_CHK:
            begin
                // Pull the next younger entry down, or close the gap count
                if (sh_more)
                begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = sh_inc[IDX_W-1:0];
                end
                else
                begin
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end
            art_pkg::S_DROP_WR:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = sh_reg;
                sh_next         = sh_inc[IDX_W-1:0];
            end
            art_pkg::S_DONE:
            begin
                flush_en = 1'b1;
            end
            default:
            begin
                flush_en = 1'b0;
            end
        endcase
    end

    // Hold one result back so the final one can carry last
    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        pend_res_next   = pend_res_reg;
        pend_id_next    = pend_id_reg;
        out_valid_next  = 1'b0;
        out_last_next   = 1'b0;
        out_res_next    = out_res_reg;
        out_id_next     = out_id_reg;
        if (push_en)
        begin
            out_valid_next  = pend_valid_reg;
            out_res_next    = pend_res_reg;
            out_id_next     = pend_id_reg;
            pend_valid_next = 1'b1;
            pend_res_next   = push_res;
            pend_id_next    = push_id;
        end
        else if (flush_en)
        begin
            out_valid_next  = pend_valid_reg;
            out_last_next   = 1'b1;
            out_res_next    = pend_res_reg;
            out_id_next     = pend_id_reg;
            pend_valid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= art_pkg::S_IDLE;
            cnt_reg        <= '0;
            idx_reg        <= '0;
            sh_reg         <= '0;
            n_reg          <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            idx_reg        <= idx_next;
            sh_reg         <= sh_next;
            n_reg          <= n_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            out_last_reg   <= out_last_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg     <= operation;
            now_reg    <= now_ms;
            id_reg     <= send_id;
            want_reg   <= want_ack;
            expack_reg <= expected_ack;
            flood_reg  <= via_flood;
            hop_reg    <= hop_count;
            ackval_reg <= ack_value;
        end
        wait_reg     <= wait_next;
        pend_res_reg <= pend_res_next;
        pend_id_reg  <= pend_id_next;
        out_res_reg  <= out_res_next;
        out_id_reg   <= out_id_next;
    end

    assign busy      = (state_reg != art_pkg::S_IDLE);
    assign valid     = out_valid_reg;
    assign event_res = out_res_reg;
    assign event_id  = out_id_reg;
    assign last      = out_last_reg;

    // Checks
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(art_pkg::SLOTS))
        else $error("entry count beyond slot count");

    a_wr_busy: assert property (@(posedge clk) disable iff (!rst_n)
        mem_req.wr_en |-> (state_reg != art_pkg::S_IDLE))
        else $error("table written while idle");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_last_reg) |-> (state_reg == art_pkg::S_IDLE && !pend_valid_reg))
        else $error("final result while item still in work");

    a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
        ##1 (cnt_reg == $past(cnt_reg) || cnt_reg == $past(cnt_reg) + CNT_W'(1)
             || cnt_reg == $past(cnt_reg) - CNT_W'(1)))
        else $error("entry count jumped");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (operation == art_pkg::OP_REGISTER || operation == art_pkg::OP_ACK
                    || operation == art_pkg::OP_TICK)) |=> busy)
        else $error("accepted item did not start");

endmodule

@@ sv/ack_retry_tracker.sv @@
// Tracks up to eight sent messages awaiting an ack. Raise start with busy low
// to issue one item (register, ack or tick); busy stays high until the item is
// fully handled. Each result appears on event_res/event_id for exactly one
// cycle with valid high, and last marks the final result of the item; the
// receiver cannot stall, so it must take every strobed result. The final
// result shows in the same cycle as busy falls. Entries live in a RAM with one
// read and one write port, read one slot at a time: a register item passes a
// check state, then a write state if it is tracked, then a done state; an ack
// reads and checks each slot searched, moves each younger slot down after a
// match and then finishes; a tick reads and checks each slot visited, moves
// each younger slot down for each failed entry, finishes, and emits at
// most eight results. An unknown operation is dropped without raising busy.
// Configuration is written through wr_en/wr_index/wr_data while busy is low.
module ack_retry_tracker
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           wr_en,
    input  logic [art_pkg::CFG_IDX_W-1:0]  wr_index,
    input  logic [art_pkg::CFG_DATA_W-1:0] wr_data,
    input  logic                           start,
    output logic                           busy,
    input  logic [1:0]                     operation,
    input  logic [31:0]                    now_ms,
    input  logic [31:0]                    send_id,
    input  logic                           want_ack,
    input  logic [31:0]                    expected_ack,
    input  logic                           via_flood,
    input  logic [6:0]                     hop_count,
    input  logic [31:0]                    ack_value,
    output logic                           valid,
    output logic [2:0]                     event_res,
    output logic [31:0]                    event_id,
    output logic                           last
);

    art_pkg::cfg_t     cfg_reg;
    art_pkg::mem_req_t mem_req;
    art_pkg::entry_t   rd_data;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_pending    <= 4'd8;
            cfg_reg.max_attempts   <= 4'd3;
            cfg_reg.flood_timeout  <= 24'd12000;
            cfg_reg.direct_base    <= 24'd3000;
            cfg_reg.direct_per_hop <= 16'd500;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                art_pkg::REG_MAX_PENDING:    cfg_reg.max_pending    <= wr_data[3:0];
                art_pkg::REG_MAX_ATTEMPTS:   cfg_reg.max_attempts   <= wr_data[3:0];
                art_pkg::REG_FLOOD_TIMEOUT:  cfg_reg.flood_timeout  <= wr_data;
                art_pkg::REG_DIRECT_BASE:    cfg_reg.direct_base    <= wr_data;
                art_pkg::REG_DIRECT_PER_HOP: cfg_reg.direct_per_hop <= wr_data[15:0];
                default:                     cfg_reg <= cfg_reg;
            endcase
        end
    end

    art_ctrl u_ctrl
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .start        (start),
        .operation    (operation),
        .now_ms       (now_ms),
        .send_id      (send_id),
        .want_ack     (want_ack),
        .expected_ack (expected_ack),
        .via_flood    (via_flood),
        .hop_count    (hop_count),
        .ack_value    (ack_value),
        .busy         (busy),
        .valid        (valid),
        .event_res    (event_res),
        .event_id     (event_id),
        .last         (last),
        .mem_req      (mem_req),
        .rd_data      (rd_data)
    );

    art_mem u_mem
    (
        .clk     (clk),
        .req     (mem_req),
        .rd_data (rd_data)
    );

endmodule

@@ tb/sv/tb_ack_retry_tracker.sv @@
`timescale 1ns / 100ps

module tb_ack_retry_tracker;

    localparam int SLOTS       = art_pkg::SLOTS;
    localparam int MAX_RESULTS = art_pkg::MAX_RESULTS;
    localparam int CFG_IDX_W   = art_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W  = art_pkg::CFG_DATA_W;

    // Operation code the block must ignore
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // Cycles to let a quiet item finish before touching the registers
    localparam int SETTLE_CYCLES = 100;
    localparam int CYCLE_LIMIT   = 600000;

    typedef struct {
        logic [1:0]  op;
        logic [31:0] now;
        logic [31:0] send_id;
        logic        want_ack;
        logic [31:0] expected_ack;
        logic        via_flood;
        logic [6:0]  hop_count;
        logic [31:0] ack_value;
    } tracker_item_t;

    typedef struct {
        logic [2:0]  res;
        logic [31:0] id;
        logic        last;
    } tracker_event_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  wr_en;
    logic [CFG_IDX_W-1:0]  wr_index;
    logic [CFG_DATA_W-1:0] wr_data;
    logic                  start;
    logic                  busy;
    logic [1:0]            operation;
    logic [31:0]           now_ms;
    logic [31:0]           send_id;
    logic                  want_ack;
    logic [31:0]           expected_ack;
    logic                  via_flood;
    logic [6:0]            hop_count;
    logic [31:0]           ack_value;
    logic                  valid;
    logic [2:0]            event_res;
    logic [31:0]           event_id;
    logic                  last;

    // Shadow copy of the tracker state and its registers
    art_pkg::cfg_t   shadow_cfg;
    art_pkg::entry_t shadow_table [SLOTS];
    int unsigned     shadow_count;
    tracker_event_t  awaited_events [$];
    logic [31:0]     sim_ms;
    int              error_count = 0;
    int              cycle_count = 0;

    ack_retry_tracker u_top
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .wr_en        (wr_en),
        .wr_index     (wr_index),
        .wr_data      (wr_data),
        .start        (start),
        .busy         (busy),
        .operation    (operation),
        .now_ms       (now_ms),
        .send_id      (send_id),
        .want_ack     (want_ack),
        .expected_ack (expected_ack),
        .via_flood    (via_flood),
        .hop_count    (hop_count),
        .ack_value    (ack_value),
        .valid        (valid),
        .event_res    (event_res),
        .event_id     (event_id),
        .last         (last)
    );

    always #5 clk = ~clk;

    // Bound the run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Deadline: now plus wait, clamped at the top of the 32-bit range
    function automatic logic [31:0] deadline_after(input logic [31:0] now,
                                                   input logic [63:0] wait_ms);
        logic [63:0] sum;
        sum = {32'd0, now} + wait_ms;
        return (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
    endfunction

    // Close the gap left by a removed entry, keeping registration order
    function automatic void remove_slot(input int unsigned at);
        int unsigned k;
        for (k = at; k + 1 < shadow_count; k++)
            shadow_table[k] = shadow_table[k + 1];
        shadow_count--;
    endfunction

    // Apply one accepted item to the shadow table and queue its events
    function automatic void predict_events(input tracker_item_t it);
        tracker_event_t list [$];
        tracker_event_t ev;
        int unsigned    cap;
        int unsigned    i;
        logic [63:0]    wait_ms;
        logic           hit;
        ev.last = 1'b0;
        case (it.op)
            art_pkg::OP_REGISTER:
            begin
                cap = (shadow_cfg.max_pending < SLOTS) ? shadow_cfg.max_pending : SLOTS;
                ev.id = it.send_id;
                if (it.want_ack && shadow_count < cap)
                begin
                    wait_ms = it.via_flood ? 64'(shadow_cfg.flood_timeout)
                            : 64'(shadow_cfg.direct_base)
                              + 64'(shadow_cfg.direct_per_hop) * 64'(it.hop_count);
                    shadow_table[shadow_count].id       = it.send_id;
                    shadow_table[shadow_count].ack      = it.expected_ack;
                    shadow_table[shadow_count].deadline = deadline_after(it.now, wait_ms);
                    shadow_table[shadow_count].attempts = 4'd1;
                    shadow_table[shadow_count].flood    = it.via_flood;
                    shadow_count++;
                    ev.res = art_pkg::EV_TRACKED;
                end
                else
                begin
                    ev.res = art_pkg::EV_NOT_TRACKED;
                end
                list.insert(list.size(), ev);
            end
            art_pkg::OP_ACK:
            begin
                hit = 1'b0;
                i = 0;
                while (!hit && i < shadow_count)
                begin
                    if (shadow_table[i].ack == it.ack_value)
                    begin
                        ev.res = art_pkg::EV_ACKED;
                        ev.id = shadow_table[i].id;
                        remove_slot(i);
                        hit = 1'b1;
                    end
                    else
                    begin
                        i++;
                    end
                end
                if (!hit)
                begin
                    ev.res = art_pkg::EV_UNMATCHED;
                    ev.id = 32'd0;
                end
                list.insert(list.size(), ev);
            end
            art_pkg::OP_TICK:
            begin
                i = 0;
                while (i < shadow_count && list.size() < MAX_RESULTS)
                begin
                    if (shadow_table[i].deadline > it.now)
                    begin
                        i++;
                    end
                    else if (shadow_table[i].attempts >= shadow_cfg.max_attempts)
                    begin
                        ev.res = art_pkg::EV_FAILED;
                        ev.id = shadow_table[i].id;
                        remove_slot(i);
                        list.insert(list.size(), ev);
                    end
                    else
                    begin
                        // Retry uses the base timeout only, no per-hop term
                        shadow_table[i].attempts = shadow_table[i].attempts + 4'd1;
                        wait_ms = shadow_table[i].flood ? 64'(shadow_cfg.flood_timeout)
                                                        : 64'(shadow_cfg.direct_base);
                        shadow_table[i].deadline = deadline_after(it.now, wait_ms);
                        ev.res = art_pkg::EV_RETRANSMIT;
                        ev.id = shadow_table[i].id;
                        list.insert(list.size(), ev);
                        i++;
                    end
                end
            end
            default:
            begin
            end
        endcase
        if (list.size() > 0)
            list[list.size() - 1].last = 1'b1;
        foreach (list[k])
            awaited_events.insert(awaited_events.size(), list[k]);
    endfunction

    // Compare each strobed result with the oldest awaited event
    always @(posedge clk)
    begin : check_results
        tracker_event_t exp_ev;
        if (rst_n && valid)
        begin
            if (awaited_events.size() == 0)
            begin
                $display("%0t: unexpected result: expected none, actual res %0d id %h last %0d",
                         $time, event_res, event_id, last);
                error_count++;
            end
            else
            begin
                exp_ev = awaited_events.pop_front();
                if (event_res !== exp_ev.res)
                begin
                    $display("%0t: event_res mismatch: expected %0d actual %0d",
                             $time, exp_ev.res, event_res);
                    error_count++;
                end
                if (event_id !== exp_ev.id)
                begin
                    $display("%0t: event_id mismatch: expected %h actual %h",
                             $time, exp_ev.id, event_id);
                    error_count++;
                end
                if (last !== exp_ev.last)
                begin
                    $display("%0t: last mismatch: expected %0d actual %0d",
                             $time, exp_ev.last, last);
                    error_count++;
                end
            end
        end
    end

    // Issue one item, idling first at the given rate; start stays high on return
    task automatic send_item(input tracker_item_t it, input int idle_pct);
        int gap;
        gap = 0;
        while ($urandom_range(99) < idle_pct && gap < 40)
            gap++;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start        <= 1'b1;
        operation    <= it.op;
        now_ms       <= it.now;
        send_id      <= it.send_id;
        want_ack     <= it.want_ack;
        expected_ack <= it.expected_ack;
        via_flood    <= it.via_flood;
        hop_count    <= it.hop_count;
        ack_value    <= it.ack_value;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predict_events(it);
    endtask

    // Hold off the sender until every awaited event is in, then let the block settle
    task automatic wait_for_drain();
        start <= 1'b0;
        @(posedge clk);
        while (awaited_events.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= value;
        @(posedge clk);
        case (idx)
            art_pkg::REG_MAX_PENDING:    shadow_cfg.max_pending    = value[3:0];
            art_pkg::REG_MAX_ATTEMPTS:   shadow_cfg.max_attempts   = value[3:0];
            art_pkg::REG_FLOOD_TIMEOUT:  shadow_cfg.flood_timeout  = value[23:0];
            art_pkg::REG_DIRECT_BASE:    shadow_cfg.direct_base    = value[23:0];
            art_pkg::REG_DIRECT_PER_HOP: shadow_cfg.direct_per_hop = value[15:0];
            default:
            begin
            end
        endcase
    endtask

    // Write all registers; unused upper data bits carry noise
    task automatic apply_config(input art_pkg::cfg_t c);
        logic [CFG_DATA_W-1:0] noise;
        noise = CFG_DATA_W'($urandom);
        write_reg(art_pkg::REG_MAX_PENDING,    {noise[23:4], c.max_pending});
        write_reg(art_pkg::REG_MAX_ATTEMPTS,   {noise[23:4], c.max_attempts});
        write_reg(art_pkg::REG_FLOOD_TIMEOUT,  c.flood_timeout);
        write_reg(art_pkg::REG_DIRECT_BASE,    c.direct_base);
        write_reg(art_pkg::REG_DIRECT_PER_HOP, {noise[23:16], c.direct_per_hop});
        wr_en <= 1'b0;
    endtask

    function automatic tracker_item_t make_item(input logic [1:0] op, input logic [31:0] now,
                                                input logic [31:0] id, input logic want,
                                                input logic [31:0] eack, input logic flood,
                                                input logic [6:0] hops,
                                                input logic [31:0] aval);
        tracker_item_t it;
        it.op = op;
        it.now = now;
        it.send_id = id;
        it.want_ack = want;
        it.expected_ack = eack;
        it.via_flood = flood;
        it.hop_count = hops;
        it.ack_value = aval;
        return it;
    endfunction

    // Random item; time advances at a pace that lets entries expire now and then
    function automatic tracker_item_t make_random_item();
        tracker_item_t it;
        int unsigned   pick;
        int unsigned   span;
        pick = $urandom_range(99);
        it.op = (pick < 40) ? art_pkg::OP_REGISTER
              : (pick < 65) ? art_pkg::OP_ACK
              : (pick < 95) ? art_pkg::OP_TICK : OP_UNUSED;
        span = ((shadow_cfg.flood_timeout > shadow_cfg.direct_base)
                ? shadow_cfg.flood_timeout : shadow_cfg.direct_base) / 3 + 50;
        sim_ms = sim_ms + $urandom_range(span);
        pick = $urandom_range(39);
        if (pick == 0)
            it.now = 32'hFFFF_FFFF;
        else if (pick < 3)
            it.now = $urandom;
        else
            it.now = sim_ms;
        it.send_id = $urandom;
        it.want_ack = ($urandom_range(9) != 0);
        it.expected_ack = ($urandom_range(3) == 0) ? 32'($urandom_range(3)) : 32'($urandom);
        it.via_flood = 1'($urandom_range(1));
        it.hop_count = ($urandom_range(9) == 0) ? 7'($urandom_range(127, 65))
                                                : 7'($urandom_range(64));
        pick = $urandom_range(9);
        if (shadow_count > 0 && pick < 6)
            it.ack_value = shadow_table[$urandom_range(shadow_count - 1)].ack;
        else if (pick < 8)
            it.ack_value = $urandom_range(3);
        else
            it.ack_value = $urandom;
        return it;
    endfunction

    // Every operation, duplicate ack values, saturation, retry and failure at reset settings
    task automatic test_directed_ops();
        send_item(make_item(art_pkg::OP_REGISTER, 32'd1000, 32'h0000_00A0, 1'b0, 32'd7, 1'b0,
                            7'd0, 32'd0), 0);
        send_item(make_item(art_pkg::OP_REGISTER, 32'd1000, 32'h0000_0000, 1'b1, 32'd0, 1'b0,
                            7'd0, 32'd0), 0);
        send_item(make_item(art_pkg::OP_REGISTER, 32'd1000, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF,
                            1'b1, 7'd0, 32'd0), 0);
        send_item(make_item(art_pkg::OP_REGISTER, 32'hFFFF_FF00, 32'h5A5A_5A5A, 1'b1,
                            32'h0000_1234, 1'b0, 7'd127, 32'd0), 0);
        send_item(make_item(art_pkg::OP_REGISTER, 32'd2000, 32'h0000_0011, 1'b1, 32'h0000_1234,
                            1'b0, 7'd64, 32'd0), 0);
        send_item(make_item(art_pkg::OP_ACK, 32'd2000, 32'd0, 1'b0, 32'd0, 1'b0, 7'd0,
                            32'h0000_DEAD), 0);
        // Oldest of two entries with the same ack value goes first
        send_item(make_item(art_pkg::OP_ACK, 32'd2000, 32'd0, 1'b0, 32'd0, 1'b0, 7'd0,
                            32'h0000_1234), 0);
        send_item(make_item(art_pkg::OP_TICK, 32'd3999, 32'd0, 1'b0, 32'd0, 1'b0, 7'd0,
                            32'd0), 0);
        send_item(make_item(OP_UNUSED, 32'd5000, 32'h1234_5678, 1'b1, 32'd9, 1'b1, 7'd3,
                            32'd0), 0);
        send_item(make_item(art_pkg::OP_TICK, 32'd4000, 32'd0, 1'b0, 32'd0, 1'b0, 7'd0,
                            32'd0), 0);
        send_item(make_item(art_pkg::OP_TICK, 32'd20000, 32'd0, 1'b0, 32'd0, 1'b0, 7'd0,
                            32'd0), 0);
        send_item(make_item(art_pkg::OP_TICK, 32'd40000, 32'd0, 1'b0, 32'd0, 1'b0, 7'd0,
                            32'd0), 0);
        send_item(make_item(art_pkg::OP_TICK, 32'hFFFF_FFFF, 32'd0, 1'b0, 32'd0, 1'b0, 7'd0,
                            32'd0), 0);
        send_item(make_item(art_pkg::OP_ACK, 32'd0, 32'd0, 1'b0, 32'd0, 1'b0, 7'd0,
                            32'd0), 0);
        send_item(make_item(art_pkg::OP_ACK, 32'd0, 32'd0, 1'b0, 32'd0, 1'b0, 7'd0,
                            32'h0000_1234), 0);
    endtask

    // Capacity limit, zero capacity and immediate failure with no attempts allowed
    task automatic test_limits();
        wait_for_drain();
        apply_config('{max_pending: 4'd2, max_attempts: 4'd0, flood_timeout: 24'd0,
                       direct_base: 24'hFF_FFFF, direct_per_hop: 16'hFFFF});
        send_item(make_item(art_pkg::OP_REGISTER, 32'h8000_0000, 32'hC0DE_0001, 1'b1,
                            32'hAAAA_5555, 1'b0, 7'd127, 32'd0), 0);
        send_item(make_item(art_pkg::OP_REGISTER, 32'd100, 32'hC0DE_0002, 1'b1, 32'h5555_AAAA,
                            1'b1, 7'd0, 32'd0), 0);
        send_item(make_item(art_pkg::OP_REGISTER, 32'd100, 32'hC0DE_0003, 1'b1, 32'd1, 1'b1,
                            7'd0, 32'd0), 0);
        send_item(make_item(art_pkg::OP_TICK, 32'd100, 32'd0, 1'b0, 32'd0, 1'b0, 7'd0,
                            32'd0), 0);
        wait_for_drain();
        apply_config('{max_pending: 4'd0, max_attempts: 4'd0, flood_timeout: 24'd0,
                       direct_base: 24'hFF_FFFF, direct_per_hop: 16'hFFFF});
        send_item(make_item(art_pkg::OP_REGISTER, 32'd200, 32'hC0DE_0004, 1'b1, 32'd2, 1'b1,
                            7'd0, 32'd0), 0);
        send_item(make_item(art_pkg::OP_TICK, 32'hFFFF_FFFF, 32'd0, 1'b0, 32'd0, 1'b0, 7'd0,
                            32'd0), 0);
    endtask

    // Mixed random traffic under one register setting and one sender idle rate
    task automatic test_random_traffic(input art_pkg::cfg_t c, input int idle_pct,
                                       input int n);
        tracker_item_t it;
        int            sent;
        wait_for_drain();
        apply_config(c);
        sim_ms = $urandom_range(1 << 20);
        sent = 0;
        while (sent < n)
        begin
            it = make_random_item();
            send_item(it, idle_pct);
            if (it.op != OP_UNUSED)
                sent++;
            if (sent == n / 2 || $urandom_range(63) == 0)
                wait_for_drain();
        end
    endtask

    initial
    begin : run_tests
        art_pkg::cfg_t mixed_cfg;
        rst_n        = 1'b0;
        wr_en        = 1'b0;
        wr_index     = '0;
        wr_data      = '0;
        start        = 1'b0;
        operation    = art_pkg::OP_REGISTER;
        now_ms       = '0;
        send_id      = '0;
        want_ack     = 1'b0;
        expected_ack = '0;
        via_flood    = 1'b0;
        hop_count    = '0;
        ack_value    = '0;
        sim_ms       = '0;
        shadow_count = 0;
        shadow_cfg   = '{max_pending: 4'd8, max_attempts: 4'd3, flood_timeout: 24'd12000,
                         direct_base: 24'd3000, direct_per_hop: 16'd500};
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_ops();
        test_limits();
        test_random_traffic('{max_pending: 4'd8, max_attempts: 4'd3, flood_timeout: 24'd12000,
                              direct_base: 24'd3000, direct_per_hop: 16'd500}, 0, 97);
        test_random_traffic('{max_pending: 4'd15, max_attempts: 4'd15,
                              flood_timeout: 24'hFF_FFFF, direct_base: 24'hFF_FFFF,
                              direct_per_hop: 16'hFFFF}, 73, 97);
        test_random_traffic('{max_pending: 4'd4, max_attempts: 4'd1, flood_timeout: 24'd0,
                              direct_base: 24'd0, direct_per_hop: 16'd0}, 10, 97);
        mixed_cfg.max_pending    = 4'($urandom_range(15, 1));
        mixed_cfg.max_attempts   = 4'($urandom_range(15));
        mixed_cfg.flood_timeout  = 24'($urandom_range(20000));
        mixed_cfg.direct_base    = 24'($urandom_range(20000));
        mixed_cfg.direct_per_hop = 16'($urandom);
        test_random_traffic(mixed_cfg, 73, 97);

        wait_for_drain();
        if (error_count == 0 && awaited_events.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
